@@ hdl/ndg_pkg.sv @@
// ----------------------------------------------------------------------------
// ndg_pkg
// Shared types, widths and codes for the nearest-neighbor downscaler that
// turns an RGB pixel stream into sampled gray values.
// ----------------------------------------------------------------------------
package ndg_pkg;

    // Field widths
    localparam int SRC_DIM_W  = 12;
    localparam int FMT_W      = 2;
    localparam int PIX_W      = 24;
    localparam int GRAY_W     = 8;
    localparam int OUT_X_W    = 8;
    localparam int OUT_Y_W    = 7;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Output frame size defaults
    localparam int OUT_WIDTH_DEF  = 160;
    localparam int OUT_HEIGHT_DEF = 120;

    // Pixel format codes
    localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB888 = 2'd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

    // Reset values of the registers
    localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST  = 12'd320;
    localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST = 12'd240;

    // Luma weights
    localparam logic [7:0] W_RED   = 8'd77;
    localparam logic [7:0] W_GREEN = 8'd150;
    localparam logic [7:0] W_BLUE  = 8'd29;

    typedef struct packed {
        logic [SRC_DIM_W-1:0] src_width;
        logic [SRC_DIM_W-1:0] src_height;
        logic [FMT_W-1:0]     pixel_format;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_word;
        logic             frame_start;
    } pix_item_t;

endpackage

@@ hdl/ndg_luma.sv @@
// ----------------------------------------------------------------------------
// ndg_luma
// Gray value of one pixel: (77R + 150G + 29B) >> 8. RGB565 channels are
// widened to 8 bits by left shifts first.
// ----------------------------------------------------------------------------
module ndg_luma (
    input  logic [ndg_pkg::PIX_W-1:0]  pixel_word,
    input  logic [ndg_pkg::FMT_W-1:0]  pixel_format,
    output logic [ndg_pkg::GRAY_W-1:0] gray
);

    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] sum;

    // Channel unpack
    always_comb begin
        if (pixel_format == ndg_pkg::FMT_RGB565) begin
            red   = {pixel_word[15:11], 3'b000};
            green = {pixel_word[10:5], 2'b00};
            blue  = {pixel_word[4:0], 3'b000};
        end else begin
            red   = pixel_word[23:16];
            green = pixel_word[15:8];
            blue  = pixel_word[7:0];
        end
    end

    // Weighted sum, max 256*255 so 16 bits hold it
    assign sum = 16'(red * ndg_pkg::W_RED) + 16'(green * ndg_pkg::W_GREEN)
               + 16'(blue * ndg_pkg::W_BLUE);
    assign gray = sum[15:8];

endmodule

@@ hdl/ndg_core.sv @@
// ----------------------------------------------------------------------------
// ndg_core
// Source/output position tracking and the result register. Sampling test
// floor(acc/OUT) == src is done as src*OUT <= acc < src*OUT + OUT, with
// src*OUT kept as a running base register.
// ----------------------------------------------------------------------------
module ndg_core #(
    parameter int OUT_WIDTH  = ndg_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = ndg_pkg::OUT_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  ndg_pkg::pix_item_t            item,
    input  ndg_pkg::cfg_t                 cfg,
    output logic                          res_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ndg_pkg::M_TDATA_W-1:0] m_tdata,   // gray, out_x, out_y, zero pad
    output logic                          m_tlast,   // frame_done
    output logic                          m_tuser    // error
);

    localparam int SW     = ndg_pkg::SRC_DIM_W;
    localparam int OCOL_W = $clog2(OUT_WIDTH + 1);
    localparam int OROW_W = $clog2(OUT_HEIGHT + 1);
    localparam int CACC_W = $clog2(OUT_WIDTH * (2 ** SW));
    localparam int RACC_W = $clog2(OUT_HEIGHT * (2 ** SW));

    localparam logic [OCOL_W-1:0] OW_C  = OCOL_W'(OUT_WIDTH);
    localparam logic [OROW_W-1:0] OH_C  = OROW_W'(OUT_HEIGHT);
    localparam logic [CACC_W-1:0] OW_A  = CACC_W'(OUT_WIDTH);
    localparam logic [RACC_W-1:0] OH_A  = RACC_W'(OUT_HEIGHT);
    localparam logic [SW-1:0]     OW_S  = SW'(OUT_WIDTH);
    localparam logic [SW-1:0]     OH_S  = SW'(OUT_HEIGHT);

    // Counter state
    logic [SW-1:0]     src_col_reg,  src_col_next;
    logic [SW-1:0]     src_row_reg,  src_row_next;
    logic [OCOL_W-1:0] out_col_reg,  out_col_next;
    logic [OROW_W-1:0] out_row_reg,  out_row_next;
    logic [CACC_W-1:0] col_acc_reg,  col_acc_next;
    logic [RACC_W-1:0] row_acc_reg,  row_acc_next;
    logic [CACC_W-1:0] col_base_reg, col_base_next;
    logic [RACC_W-1:0] row_base_reg, row_base_next;
    logic              dropped_reg,  dropped_next;

    // Result register
    logic                        res_valid_reg;
    logic [ndg_pkg::GRAY_W-1:0]  res_gray_reg;
    logic [ndg_pkg::OUT_X_W-1:0] res_x_reg;
    logic [ndg_pkg::OUT_Y_W-1:0] res_y_reg;
    logic                        res_done_reg;
    logic                        res_err_reg;

    // Counters as seen by this item (frame start restarts them)
    logic [SW-1:0]     e_src_col, e_src_row;
    logic [OCOL_W-1:0] e_out_col;
    logic [OROW_W-1:0] e_out_row;
    logic [CACC_W-1:0] e_col_acc, e_col_base;
    logic [RACC_W-1:0] e_row_acc, e_row_base;
    logic              e_dropped;

    logic              setup_ok, live, row_sel, col_sel, emit, err_out, col_wrap;
    logic [CACC_W:0]   col_diff;
    logic [RACC_W:0]   row_diff;
    logic [SW-1:0]     src_col_inc;
    logic [ndg_pkg::GRAY_W-1:0] gray;

    assign e_src_col  = item.frame_start ? '0 : src_col_reg;
    assign e_src_row  = item.frame_start ? '0 : src_row_reg;
    assign e_out_col  = item.frame_start ? '0 : out_col_reg;
    assign e_out_row  = item.frame_start ? '0 : out_row_reg;
    assign e_col_acc  = item.frame_start ? '0 : col_acc_reg;
    assign e_row_acc  = item.frame_start ? '0 : row_acc_reg;
    assign e_col_base = item.frame_start ? '0 : col_base_reg;
    assign e_row_base = item.frame_start ? '0 : row_base_reg;
    assign e_dropped  = item.frame_start ? 1'b0 : dropped_reg;

    // Setup check and selection tests
    assign setup_ok = (cfg.pixel_format == ndg_pkg::FMT_RGB565 ||
                       cfg.pixel_format == ndg_pkg::FMT_RGB888) &&
                      cfg.src_width >= OW_S && cfg.src_height >= OH_S;
    assign live     = setup_ok && !e_dropped && (e_src_row < cfg.src_height);
    assign row_diff = {1'b0, e_row_acc} - {1'b0, e_row_base};
    assign col_diff = {1'b0, e_col_acc} - {1'b0, e_col_base};
    assign row_sel  = (e_out_row < OH_C) && !row_diff[RACC_W] &&
                      (row_diff[RACC_W-1:0] < OH_A);
    assign col_sel  = (e_out_col < OW_C) && !col_diff[CACC_W] &&
                      (col_diff[CACC_W-1:0] < OW_A);
    assign emit     = live && row_sel && col_sel;
    assign err_out  = !setup_ok && item.frame_start;

    assign src_col_inc = e_src_col + 1'b1;
    assign col_wrap    = src_col_inc >= cfg.src_width;

    ndg_luma u_luma (
        .pixel_word   (item.pixel_word),
        .pixel_format (cfg.pixel_format),
        .gray         (gray)
    );

    // Next counter state
    always_comb begin
        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        col_acc_next  = col_acc_reg;
        row_acc_next  = row_acc_reg;
        col_base_next = col_base_reg;
        row_base_next = row_base_reg;
        dropped_next  = dropped_reg;
        if (step) begin
            src_col_next  = e_src_col;
            src_row_next  = e_src_row;
            out_col_next  = e_out_col;
            out_row_next  = e_out_row;
            col_acc_next  = e_col_acc;
            row_acc_next  = e_row_acc;
            col_base_next = e_col_base;
            row_base_next = e_row_base;
            dropped_next  = e_dropped;
            if (!setup_ok) begin
                dropped_next = 1'b1;
            end else if (live) begin
                if (emit) begin
                    out_col_next = e_out_col + 1'b1;
                    col_acc_next = e_col_acc + CACC_W'(cfg.src_width);
                end
                if (col_wrap) begin
                    src_col_next  = '0;
                    col_base_next = '0;
                    src_row_next  = e_src_row + 1'b1;
                    row_base_next = e_row_base + OH_A;
                    if (row_sel) begin
                        out_row_next = e_out_row + 1'b1;
                        row_acc_next = e_row_acc + RACC_W'(cfg.src_height);
                        out_col_next = '0;
                        col_acc_next = '0;
                    end
                end else begin
                    src_col_next  = src_col_inc;
                    col_base_next = e_col_base + OW_A;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            col_acc_reg  <= '0;
            row_acc_reg  <= '0;
            col_base_reg <= '0;
            row_base_reg <= '0;
            dropped_reg  <= 1'b0;
        end else begin
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            col_acc_reg  <= col_acc_next;
            row_acc_reg  <= row_acc_next;
            col_base_reg <= col_base_next;
            row_base_reg <= row_base_next;
            dropped_reg  <= dropped_next;
        end
    end

    // Result register: valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (step) begin
            res_valid_reg <= emit || err_out;
        end else if (m_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge aclk) begin
        if (step) begin
            res_err_reg  <= err_out;
            res_gray_reg <= emit ? gray : '0;
            res_x_reg    <= emit ? ndg_pkg::OUT_X_W'(e_out_col) : '0;
            res_y_reg    <= emit ? ndg_pkg::OUT_Y_W'(e_out_row) : '0;
            res_done_reg <= emit && (e_out_col == OW_C - 1'b1) &&
                            (e_out_row == OH_C - 1'b1);
        end
    end

    assign res_ready = !res_valid_reg || m_tready;
    assign m_tvalid  = res_valid_reg;
    assign m_tdata   = {1'b0, res_y_reg, res_x_reg, res_gray_reg};
    assign m_tlast   = res_done_reg;
    assign m_tuser   = res_err_reg;

    // Checks
    a_err_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && res_err_reg |-> res_gray_reg == '0 && res_x_reg == '0 &&
        res_y_reg == '0 && !res_done_reg)
        else $error("error result carries nonzero payload");

    a_out_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_col_reg <= OW_C)
        else $error("output column past frame width");

    a_out_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_row_reg <= OH_C)
        else $error("output row past frame height");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.frame_start && setup_ok |=> !dropped_reg)
        else $error("valid frame start left frame dropped");

    a_bad_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !setup_ok |=> dropped_reg && !(res_valid_reg && !res_err_reg))
        else $error("invalid setup produced a pixel result");

endmodule

@@ hdl/nearest_downscale_to_gray_top.sv @@
// ----------------------------------------------------------------------------
// nearest_downscale_to_gray_top
// Nearest-neighbor downscaler of a raster RGB565/RGB888 stream to a gray
// image of OUT_WIDTH x OUT_HEIGHT, one sampled gray value per result.
//
//   channel | dir | tdata                       | tuser       | tlast
//   --------+-----+-----------------------------+-------------+-----------
//   s_      | in  | pixel_word[23:0]            | frame_start | -
//   m_      | out | gray[7:0] out_x[15:8]       | error       | frame_done
//           |     | out_y[22:16], bit 23 zero   |             |
//   cfg_    | in  | write port: src_width, src_height, pixel_format
//
// One pixel per cycle sustained while the result is not stalled; an input
// transfer reaches its result through the input register, then the counter
// update into the result register. A stalled result holds the result register;
// one more pixel waits in the input register before s_tready drops.
// Reset is synchronous, active low; registers return to 320 x 240 RGB565.
// ----------------------------------------------------------------------------
module nearest_downscale_to_gray_top #(
    parameter int OUT_WIDTH  = ndg_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = ndg_pkg::OUT_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [ndg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ndg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Pixel input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ndg_pkg::PIX_W-1:0]      s_tdata,   // pixel_word
    input  logic                           s_tuser,   // frame_start
    // Gray output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ndg_pkg::M_TDATA_W-1:0]  m_tdata,   // gray, out_x, out_y, zero pad
    output logic                           m_tlast,   // frame_done
    output logic                           m_tuser    // error
);

    ndg_pkg::cfg_t      cfg_reg;
    ndg_pkg::pix_item_t in_item_reg;
    logic               in_valid_reg;
    logic               res_ready;
    logic               step;
    logic               load;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width    <= ndg_pkg::SRC_WIDTH_RST;
            cfg_reg.src_height   <= ndg_pkg::SRC_HEIGHT_RST;
            cfg_reg.pixel_format <= ndg_pkg::FMT_RGB565;
        end else if (cfg_we) begin
            case (cfg_index)
                ndg_pkg::REG_SRC_WIDTH:    cfg_reg.src_width  <= cfg_wdata;
                ndg_pkg::REG_SRC_HEIGHT:   cfg_reg.src_height <= cfg_wdata;
                ndg_pkg::REG_PIXEL_FORMAT: begin
                    cfg_reg.pixel_format <= cfg_wdata[ndg_pkg::FMT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Input register
    assign step     = in_valid_reg && res_ready;
    assign s_tready = !in_valid_reg || res_ready;
    assign load     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (load) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            in_item_reg.pixel_word  <= s_tdata;
            in_item_reg.frame_start <= s_tuser;
        end
    end

    ndg_core #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
